### sv/prhc_pkg.sv
// Shared types and constants of the polar/rectangular heading converter.
// Holds the pipeline control word, the turn constants and the arctangent table.
// Depends on nothing; every other file of the block imports it.
package prhc_pkg;

   localparam int TURN_W = 32;
   localparam int GUARD = 8;

   localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;
   localparam logic [TURN_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

   localparam int GAIN_W = 31;
   localparam logic [GAIN_W-1:0] UNIT_GAIN = 31'h4000_0000;

   typedef struct packed {
      logic valid;
      logic op;
      logic unit;
   } ctrl_type;

   function automatic logic [GAIN_W-1:0] inv_gain(input int unsigned iterations);
      logic [63:0] tail;
      begin
         tail = 64'd434688583 >> (2 * iterations);
         inv_gain = GAIN_W'(64'd652032874 + tail);
      end
   endfunction

   function automatic logic [TURN_W-1:0] atan_step(input int unsigned idx);
      begin
         case (idx)
            0: atan_step = 32'd536870912;
            1: atan_step = 32'd316933406;
            2: atan_step = 32'd167458907;
            3: atan_step = 32'd85004756;
            4: atan_step = 32'd42667331;
            5: atan_step = 32'd21354465;
            6: atan_step = 32'd10679838;
            7: atan_step = 32'd5340245;
            8: atan_step = 32'd2670163;
            9: atan_step = 32'd1335087;
            10: atan_step = 32'd667544;
            11: atan_step = 32'd333772;
            12: atan_step = 32'd166886;
            13: atan_step = 32'd83443;
            14: atan_step = 32'd41722;
            15: atan_step = 32'd20861;
            16: atan_step = 32'd10430;
            17: atan_step = 32'd5215;
            18: atan_step = 32'd2608;
            19: atan_step = 32'd1304;
            20: atan_step = 32'd652;
            21: atan_step = 32'd326;
            22: atan_step = 32'd163;
            23: atan_step = 32'd81;
            default: atan_step = '0;
         endcase
      end
   endfunction

endpackage

### sv/prhc_cell.sv
// One micro-rotation cell of the CORDIC chain, with its own pipeline register.
// Rotates towards zero angle in polar mode and towards the x axis in vector mode.
// Depends on prhc_pkg for the control word and the arctangent table.
module prhc_cell
   import prhc_pkg::*;
#(
   parameter int XW = 43,
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             up_ctrl,
   input  logic signed [XW-1:0] up_x,
   input  logic signed [XW-1:0] up_y,
   input  logic [TURN_W-1:0]    up_z,
   output logic                 up_ready,
   output ctrl_type             dn_ctrl,
   output logic signed [XW-1:0] dn_x,
   output logic signed [XW-1:0] dn_y,
   output logic [TURN_W-1:0]    dn_z,
   input  logic                 dn_ready
);

   localparam logic [TURN_W-1:0] STEP_ANGLE = atan_step(STEP);

   ctrl_type             ctrl_ff;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] y_ff, y_in;
   logic [TURN_W-1:0]    z_ff, z_in;
   logic                 ccw;

   assign up_ready = !ctrl_ff.valid || dn_ready;

   always_comb begin
      ccw = up_ctrl.op ? !up_z[TURN_W-1] : up_y[XW-1];
      x_in = up_x;
      y_in = up_y;
      z_in = up_z;
      if (!up_ctrl.unit) begin
         if (ccw) begin
            x_in = up_x - (up_y >>> STEP);
            y_in = up_y + (up_x >>> STEP);
            z_in = up_z - STEP_ANGLE;
         end else begin
            x_in = up_x + (up_y >>> STEP);
            y_in = up_y - (up_x >>> STEP);
            z_in = up_z + STEP_ANGLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (up_ready) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_ctrl.valid) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_x = x_ff;
   assign dn_y = y_ff;
   assign dn_z = z_ff;

endmodule

### sv/prhc_gain.sv
// Gain correction for both coordinate lanes: absolute value, split multiply by
// the inverse CORDIC gain, then rounding to nearest with ties away from zero.
// Depends on prhc_pkg; three pipeline stages with the same handshake as the cells.
module prhc_gain
   import prhc_pkg::*;
#(
   parameter int XW = 43,
   parameter int ITERATIONS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_type              up_ctrl,
   input  logic signed [XW-1:0]  up_x,
   input  logic signed [XW-1:0]  up_y,
   input  logic [TURN_W-1:0]     up_z,
   output logic                  up_ready,
   output ctrl_type              dn_ctrl,
   output logic [XW-GUARD-1:0]   dn_x_mag,
   output logic [XW-GUARD-1:0]   dn_y_mag,
   output logic [1:0]            dn_neg,
   output logic [TURN_W-1:0]     dn_z,
   input  logic                  dn_ready
);

   localparam int RW = XW - GUARD;
   localparam int PW = 2 * 32 - 1;
   localparam logic [GAIN_W-1:0] INV_GAIN = inv_gain(ITERATIONS);
   localparam logic [63:0] ROUND_HALF = 64'd1 << (GUARD - 1);

   ctrl_type          c1_ff, c2_ff, c3_ff;
   logic [TURN_W-1:0] z1_ff, z2_ff, z3_ff;
   logic              r1, r2, r3;

   logic signed [XW-1:0] lane_v [2];
   logic [XW-1:0]        u1_ff [2];
   logic [XW-1:0]        u1_in [2];
   logic [1:0]           neg1_ff, neg2_ff, neg3_ff;
   logic [63:0]          u_wide [2];
   logic [GAIN_W-1:0]    gain;
   logic [PW-1:0]        p_hi_ff [2];
   logic [PW-1:0]        p_hi_in [2];
   logic [PW-1:0]        p_lo_ff [2];
   logic [PW-1:0]        p_lo_in [2];
   logic [63:0]          q [2];
   logic [RW-1:0]        r_ff [2];
   logic [RW-1:0]        r_in [2];

   assign r3 = !c3_ff.valid || dn_ready;
   assign r2 = !c2_ff.valid || r3;
   assign r1 = !c1_ff.valid || r2;
   assign up_ready = r1;

   assign lane_v[0] = up_x;
   assign lane_v[1] = up_y;
   assign gain = c1_ff.unit ? UNIT_GAIN : INV_GAIN;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         u1_in[l] = lane_v[l][XW-1] ? XW'(-lane_v[l]) : XW'(lane_v[l]);
         u_wide[l] = 64'(u1_ff[l]);
         p_hi_in[l] = PW'(u_wide[l][63:32]) * PW'(gain);
         p_lo_in[l] = PW'(u_wide[l][31:0]) * PW'(gain);
         q[l] = 64'({p_hi_ff[l], 2'b00}) + 64'(p_lo_ff[l] >> 30) + ROUND_HALF;
         r_in[l] = RW'(q[l] >> GUARD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
      end else begin
         if (r1) begin
            c1_ff <= up_ctrl;
         end
         if (r2) begin
            c2_ff <= c1_ff;
         end
         if (r3) begin
            c3_ff <= c2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r1 && up_ctrl.valid) begin
         u1_ff <= u1_in;
         neg1_ff <= {up_y[XW-1], up_x[XW-1]};
         z1_ff <= up_z;
      end
      if (r2 && c1_ff.valid) begin
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
         neg2_ff <= neg1_ff;
         z2_ff <= z1_ff;
      end
      if (r3 && c2_ff.valid) begin
         r_ff <= r_in;
         neg3_ff <= neg2_ff;
         z3_ff <= z2_ff;
      end
   end

   assign dn_ctrl = c3_ff;
   assign dn_x_mag = r_ff[0];
   assign dn_y_mag = r_ff[1];
   assign dn_neg = neg3_ff;
   assign dn_z = z3_ff;

endmodule

### sv/polar_rect_heading_converter_core.sv
// Top level of the polar/rectangular heading converter: input register, CORDIC
// cell chain, gain correction and the saturating output register.
// Depends on prhc_pkg, prhc_cell and prhc_gain.
//
// Usage. A request word carries req_op and the operands; with req_op high it
// converts req_magnitude_in and req_heading_in to x and y, with req_op low it
// converts req_x_in and req_y_in to a magnitude and a heading. Heading zero
// points along +y and grows counterclockwise, with the full code range one turn.
// A word is taken when req_valid is high and req_stall is low, and its result
// is handed over when rsp_valid is high and rsp_stall is low. Results leave in
// request order, one response word per request word.
// The pipeline has one input register, one cell per micro-rotation, three
// gain-correction stages and the output register.
// One word enters in every cycle while req_stall is low. When the receiver
// stalls, each stage holding a word freezes while empty stages behind it keep
// filling, and req_stall rises only once the stage after the input register
// is occupied and blocked. A synchronous reset empties every stage at once.
module polar_rect_heading_converter_core
   import prhc_pkg::*;
#(
   parameter int ITERATIONS = 16,
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic signed [COORD_WIDTH-1:0] req_x_in,
   input  logic signed [COORD_WIDTH-1:0] req_y_in,
   input  logic signed [COORD_WIDTH-1:0] req_magnitude_in,
   input  logic signed [ANGLE_WIDTH-1:0] req_heading_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_x_out,
   output logic signed [COORD_WIDTH-1:0] rsp_y_out,
   output logic [COORD_WIDTH-2:0]        rsp_magnitude_out,
   output logic signed [ANGLE_WIDTH-1:0] rsp_heading_out,
   output logic                          rsp_saturated
);

   localparam int CW = COORD_WIDTH;
   localparam int XW = CW + GUARD + 3;
   localparam int RW = XW - GUARD;
   localparam int SW = RW + 1;
   localparam logic [TURN_W-1:0] HEAD_ADJ =
      (32'd1 << (TURN_W - 1 - ANGLE_WIDTH)) - QUARTER_TURN;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-2:0] MAG_MAX = {(CW-1){1'b1}};

   // Input register.
   ctrl_type             e_ctrl_ff, e_ctrl_in;
   logic signed [XW-1:0] e_x_ff, e_x_in;
   logic signed [XW-1:0] e_y_ff, e_y_in;
   logic [TURN_W-1:0]    e_z_ff, e_z_in;
   logic                 e_ready;

   logic signed [XW-1:0] xs, ys, ms, ax, ay, mg;
   logic [TURN_W-1:0]    zr;

   always_comb begin
      xs = XW'(req_x_in);
      ys = XW'(req_y_in);
      ms = XW'(req_magnitude_in);
      ax = xs[XW-1] ? -xs : xs;
      ay = ys[XW-1] ? -ys : ys;
      mg = ms <<< GUARD;
      zr = {req_heading_in, {(TURN_W-ANGLE_WIDTH){1'b0}}} + QUARTER_TURN;
      e_ctrl_in = '{valid: req_valid, op: req_op, unit: 1'b0};
      e_x_in = '0;
      e_y_in = '0;
      e_z_in = '0;
      if (req_op) begin
         // Non-negative headings start from the negated vector.
         if (zr[TURN_W-1] ^ zr[TURN_W-2]) begin
            e_x_in = -mg;
            e_z_in = zr ^ HALF_TURN;
         end else begin
            e_x_in = mg;
            e_z_in = zr;
         end
      end else if (req_x_in == '0 && req_y_in == '0) begin
         e_ctrl_in.unit = 1'b1;
         e_z_in = QUARTER_TURN;
      end else if (req_x_in == '0) begin
         e_ctrl_in.unit = 1'b1;
         e_x_in = ay <<< GUARD;
         e_z_in = ys[XW-1] ? THREE_QUARTER_TURN : QUARTER_TURN;
      end else if (req_y_in == '0) begin
         e_ctrl_in.unit = 1'b1;
         e_x_in = ax <<< GUARD;
         e_z_in = xs[XW-1] ? HALF_TURN : '0;
      end else begin
         e_x_in = ax <<< GUARD;
         e_y_in = (xs[XW-1] ? -ys : ys) <<< GUARD;
         e_z_in = xs[XW-1] ? HALF_TURN : '0;
      end
   end

   ctrl_type             ch_ctrl [ITERATIONS+1];
   logic signed [XW-1:0] ch_x [ITERATIONS+1];
   logic signed [XW-1:0] ch_y [ITERATIONS+1];
   logic [TURN_W-1:0]    ch_z [ITERATIONS+1];
   logic                 ch_ready [ITERATIONS+1];

   assign e_ready = !e_ctrl_ff.valid || ch_ready[0];
   assign req_stall = !e_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ctrl_ff <= '0;
      end else if (e_ready) begin
         e_ctrl_ff <= e_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_ready && req_valid) begin
         e_x_ff <= e_x_in;
         e_y_ff <= e_y_in;
         e_z_ff <= e_z_in;
      end
   end

   assign ch_ctrl[0] = e_ctrl_ff;
   assign ch_x[0] = e_x_ff;
   assign ch_y[0] = e_y_ff;
   assign ch_z[0] = e_z_ff;

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
      prhc_cell #(
         .XW   (XW),
         .STEP (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_ctrl  (ch_ctrl[k]),
         .up_x     (ch_x[k]),
         .up_y     (ch_y[k]),
         .up_z     (ch_z[k]),
         .up_ready (ch_ready[k]),
         .dn_ctrl  (ch_ctrl[k+1]),
         .dn_x     (ch_x[k+1]),
         .dn_y     (ch_y[k+1]),
         .dn_z     (ch_z[k+1]),
         .dn_ready (ch_ready[k+1])
      );
   end

   ctrl_type          g_ctrl;
   logic [RW-1:0]     g_x_mag, g_y_mag;
   logic [1:0]        g_neg;
   logic [TURN_W-1:0] g_z;
   logic              o_ready;

   prhc_gain #(
      .XW         (XW),
      .ITERATIONS (ITERATIONS)
   ) u_gain (
      .clock    (clock),
      .reset    (reset),
      .up_ctrl  (ch_ctrl[ITERATIONS]),
      .up_x     (ch_x[ITERATIONS]),
      .up_y     (ch_y[ITERATIONS]),
      .up_z     (ch_z[ITERATIONS]),
      .up_ready (ch_ready[ITERATIONS]),
      .dn_ctrl  (g_ctrl),
      .dn_x_mag (g_x_mag),
      .dn_y_mag (g_y_mag),
      .dn_neg   (g_neg),
      .dn_z     (g_z),
      .dn_ready (o_ready)
   );

   // Output register with saturation.
   logic signed [SW-1:0] sv [2];
   logic signed [CW-1:0] clip_v [2];
   logic [1:0]           clip_hit;
   logic                 mag_hi, mag_sat;
   logic [CW-2:0]        mag_v;
   logic [TURN_W-1:0]    head_w;

   logic                 valid_ff;
   logic signed [CW-1:0] x_out_ff, x_out_in;
   logic signed [CW-1:0] y_out_ff, y_out_in;
   logic [CW-2:0]        mag_out_ff, mag_out_in;
   logic [ANGLE_WIDTH-1:0] head_out_ff, head_out_in;
   logic                 sat_ff, sat_in;

   assign o_ready = !valid_ff || !rsp_stall;

   always_comb begin
      sv[0] = g_neg[0] ? -$signed({1'b0, g_x_mag}) : $signed({1'b0, g_x_mag});
      sv[1] = g_neg[1] ? -$signed({1'b0, g_y_mag}) : $signed({1'b0, g_y_mag});
      for (int l = 0; l < 2; l++) begin
         if (!sv[l][SW-1] && (|sv[l][SW-2:CW-1])) begin
            clip_v[l] = CMAX;
            clip_hit[l] = 1'b1;
         end else if (sv[l][SW-1] && !(&sv[l][SW-2:CW-1])) begin
            clip_v[l] = CMIN;
            clip_hit[l] = 1'b1;
         end else begin
            clip_v[l] = sv[l][CW-1:0];
            clip_hit[l] = 1'b0;
         end
      end
      mag_hi = !sv[0][SW-1] && (|sv[0][SW-2:CW-1]);
      mag_sat = sv[0][SW-1] || mag_hi;
      if (sv[0][SW-1]) begin
         mag_v = '0;
      end else if (mag_hi) begin
         mag_v = MAG_MAX;
      end else begin
         mag_v = sv[0][CW-2:0];
      end
      head_w = g_z + HEAD_ADJ;
      if (g_ctrl.op) begin
         x_out_in = clip_v[0];
         y_out_in = clip_v[1];
         mag_out_in = '0;
         head_out_in = '0;
         sat_in = |clip_hit;
      end else begin
         x_out_in = '0;
         y_out_in = '0;
         mag_out_in = mag_v;
         head_out_in = head_w[TURN_W-1 -: ANGLE_WIDTH];
         sat_in = mag_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (o_ready) begin
         valid_ff <= g_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready && g_ctrl.valid) begin
         x_out_ff <= x_out_in;
         y_out_ff <= y_out_in;
         mag_out_ff <= mag_out_in;
         head_out_ff <= head_out_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_x_out = x_out_ff;
   assign rsp_y_out = y_out_ff;
   assign rsp_magnitude_out = mag_out_ff;
   assign rsp_heading_out = head_out_ff;
   assign rsp_saturated = sat_ff;

   // A polar word never carries rectangular coordinates, and the reverse.
   a_mag_excludes_xy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_magnitude_out != '0) |-> (rsp_x_out == '0) && (rsp_y_out == '0))
      else $error("magnitude and coordinates both non-zero");

   a_xy_excludes_polar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_x_out != '0) || (rsp_y_out != '0))
      |-> (rsp_magnitude_out == '0) && (rsp_heading_out == '0))
      else $error("coordinates carry polar fields");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated
      |-> (rsp_x_out == CMAX) || (rsp_x_out == CMIN) || (rsp_y_out == CMAX)
          || (rsp_y_out == CMIN) || (rsp_magnitude_out == MAG_MAX)
          || (rsp_magnitude_out == '0))
      else $error("saturation flag without a clipped value");

   a_stall_when_blocked: assert property (@(posedge clock) disable iff (reset)
      e_ctrl_ff.valid && !ch_ready[0] |-> req_stall)
      else $error("word taken while input register is blocked");

endmodule
